@@ src/dpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbm_pkg
// Shared types and constants of the demand-paged byte memory: command and
// status codes, the packed result item and the table control group.
// ----------------------------------------------------------------------------
package dpbm_pkg;

    localparam int TDATA_W = 32;
    localparam int VA_W    = 17;
    localparam int BYTE_W  = 8;
    localparam int PA_W    = 16;

    localparam logic [BYTE_W-1:0] FAULT_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_UNMAP = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNMAPPED = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOFRAME  = 3'd3,
        ST_GUARD    = 3'd4
    } t_status;

    // read_data sits in the lowest bits
    typedef struct packed {
        logic [PA_W-1:0]   phys_addr;
        t_status           status;
        logic [BYTE_W-1:0] read_data;
    } t_result;

    localparam int RES_W = $bits(t_result);

    typedef struct packed {
        logic map_re;
        logic map_we;
        logic used_re;
        logic used_we;
        logic used_wdata;
    } t_tbl_ctl;

endpackage

@@ src/dpbm_table.sv @@
// ----------------------------------------------------------------------------
// dpbm_table
// Page table and frame-in-use memories, each with one write port and one
// registered read port; the page table's read and write share one address.
// ----------------------------------------------------------------------------
module dpbm_table #(
    parameter int NUM_PAGES = 16,
    parameter int PG_W      = 4
) (
    input  logic                i_clk,
    input  dpbm_pkg::t_tbl_ctl  i_ctl,
    input  logic [PG_W-1:0]     i_map_addr,
    input  logic [PG_W-1:0]     i_map_wdata,
    output logic [PG_W-1:0]     o_map_rdata,
    input  logic [PG_W-1:0]     i_used_raddr,
    input  logic [PG_W-1:0]     i_used_waddr,
    output logic                o_used_rdata
);
    import dpbm_pkg::*;

    logic [PG_W-1:0] r_map [NUM_PAGES];
    logic            r_used [NUM_PAGES];
    logic [PG_W-1:0] r_map_rd;
    logic            r_used_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.map_we) begin
            r_map[i_map_addr] <= i_map_wdata;
        end
        if (i_ctl.map_re) begin
            r_map_rd <= r_map[i_map_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.used_we) begin
            r_used[i_used_waddr] <= i_ctl.used_wdata;
        end
        if (i_ctl.used_re) begin
            r_used_rd <= r_used[i_used_raddr];
        end
    end

    assign o_map_rdata  = r_map_rd;
    assign o_used_rdata = r_used_rd;

endmodule

@@ src/dpbm_store.sv @@
// ----------------------------------------------------------------------------
// dpbm_store
// Physical byte memory, single port, registered read.
// ----------------------------------------------------------------------------
module dpbm_store #(
    parameter int MEMORY_BYTES = 65536,
    parameter int MA_W         = 16
) (
    input  logic                        i_clk,
    input  logic                        i_re,
    input  logic                        i_we,
    input  logic [MA_W-1:0]             i_addr,
    input  logic [dpbm_pkg::BYTE_W-1:0] i_wdata,
    output logic [dpbm_pkg::BYTE_W-1:0] o_rdata
);
    import dpbm_pkg::*;

    logic [BYTE_W-1:0] r_mem [MEMORY_BYTES];
    logic [BYTE_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rd;

endmodule

@@ src/demand_paged_byte_memory.sv @@
// ----------------------------------------------------------------------------
// demand_paged_byte_memory
// Byte memory behind a single-level page table with demand allocation.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command per transfer (read byte, write byte, unmap
//   page); m_axis returns exactly one result per command, in order.
//   one command is in flight at a time. a mapped write, an unmap, a range
//   fault, an unmapped read and a guard write to address 0 load the result
//   register from the table lookup; a mapped read does a table read, then a
//   byte memory read.
//   a write to an unmapped page runs a next-fit search over the frame-in-use
//   memory, one frame per cycle; the single read port of that memory sets
//   this rate.
//   after reset the table and frame-in-use memories are cleared one entry a
//   cycle, all MEMORY_BYTES/PAGE_BYTES entries, with s_axis_tready low meanwhile.
//   the result sits in an output register; a new command is accepted while
//   it waits, but the next result holds in the engine until m_axis_tready.
//   PAGE_BYTES and MEMORY_BYTES are powers of two.
// ----------------------------------------------------------------------------
module demand_paged_byte_memory #(
    parameter int MEMORY_BYTES = 65536,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command[1:0], vaddr[18:2], write_data[26:19], zero fill above
    input  logic [dpbm_pkg::TDATA_W-1:0] s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // read_data[7:0], status[10:8], phys_addr[26:11], zero fill above
    output logic [dpbm_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready
);
    import dpbm_pkg::*;

    localparam int NUM_PAGES  = MEMORY_BYTES / PAGE_BYTES;
    localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OFF_W      = $clog2(PAGE_BYTES);
    localparam int MA_W       = $clog2(MEMORY_BYTES);
    localparam int CNT_W      = $clog2(NUM_PAGES + 1);
    localparam int VIRT_LIMIT = NUM_PAGES * PAGE_BYTES;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_LOOKUP = 6'b000100,
        S_ACCESS = 6'b001000,
        S_SEARCH = 6'b010000,
        S_ALLOC  = 6'b100000
    } t_state;

    function automatic logic [PG_W-1:0] next_frame(input logic [PG_W-1:0] f);
        if (32'(f) == NUM_PAGES - 1) begin
            return '0;
        end
        return f + 1'b1;
    endfunction

    function automatic logic [MA_W-1:0] phys(input logic [PG_W-1:0] f,
                                             input logic [OFF_W-1:0] o);
        return MA_W'((32'(f) << OFF_W) + 32'(o));
    endfunction

    // input fields
    logic [1:0]        in_cmd;
    logic [VA_W-1:0]   in_va;
    logic [BYTE_W-1:0] in_wd;
    assign in_cmd = s_axis_tdata[1:0];
    assign in_va  = s_axis_tdata[18:2];
    assign in_wd  = s_axis_tdata[26:19];

    t_state            r_state, n_state;
    logic [1:0]        r_cmd, n_cmd;
    logic [VA_W-1:0]   r_va, n_va;
    logic [BYTE_W-1:0] r_wd, n_wd;
    logic              r_range, n_range;
    logic [PG_W-1:0]   r_alloc, n_alloc;
    logic [PG_W-1:0]   r_cand, n_cand;
    logic [PG_W-1:0]   r_chk, n_chk;
    logic              r_chk_v, n_chk_v;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_found_ok, n_found_ok;
    logic [MA_W-1:0]   r_pa, n_pa;
    logic [PG_W-1:0]   r_clr, n_clr;
    logic              r_out_valid;
    t_result           r_res;

    t_tbl_ctl          ctl;
    logic [PG_W-1:0]   map_addr, map_wdata, map_rdata;
    logic [PG_W-1:0]   used_raddr, used_waddr;
    logic              used_rdata;
    logic              st_re, st_we;
    logic [MA_W-1:0]   st_addr;
    logic [BYTE_W-1:0] st_rdata;
    logic              load_res;
    t_result           res;
    logic              slot;
    logic              s_xfer;
    logic [PG_W-1:0]   r_page;
    logic [OFF_W-1:0]  r_offs;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign slot          = !r_out_valid || m_axis_tready;
    assign r_page        = PG_W'(32'(r_va) >> OFF_W);
    assign r_offs        = r_va[OFF_W-1:0];

    dpbm_table #(
        .NUM_PAGES (NUM_PAGES),
        .PG_W      (PG_W)
    ) u_table (
        .i_clk        (i_clk),
        .i_ctl        (ctl),
        .i_map_addr   (map_addr),
        .i_map_wdata  (map_wdata),
        .o_map_rdata  (map_rdata),
        .i_used_raddr (used_raddr),
        .i_used_waddr (used_waddr),
        .o_used_rdata (used_rdata)
    );

    dpbm_store #(
        .MEMORY_BYTES (MEMORY_BYTES),
        .MA_W         (MA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_re    (st_re),
        .i_we    (st_we),
        .i_addr  (st_addr),
        .i_wdata (r_wd),
        .o_rdata (st_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_va       = r_va;
        n_wd       = r_wd;
        n_range    = r_range;
        n_alloc    = r_alloc;
        n_cand     = r_cand;
        n_chk      = r_chk;
        n_chk_v    = r_chk_v;
        n_cnt      = r_cnt;
        n_found_ok = r_found_ok;
        n_pa       = r_pa;
        n_clr      = r_clr;
        ctl        = '0;
        map_addr   = r_page;
        map_wdata  = '0;
        used_raddr = r_cand;
        used_waddr = r_chk;
        st_re      = 1'b0;
        st_we      = 1'b0;
        st_addr    = phys(map_rdata, r_offs);
        load_res   = 1'b0;
        res        = '{phys_addr: '0, status: ST_OK, read_data: '0};

        unique case (r_state)
            S_CLEAR: begin
                ctl.map_we = 1'b1;
                ctl.used_we = 1'b1;
                map_addr = r_clr;
                used_waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == NUM_PAGES - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                map_addr = PG_W'(32'(in_va) >> OFF_W);
                if (s_xfer) begin
                    ctl.map_re = 1'b1;
                    n_cmd = in_cmd;
                    n_va = in_va;
                    n_wd = in_wd;
                    n_range = !(in_cmd == CMD_READ || in_cmd == CMD_WRITE ||
                                in_cmd == CMD_UNMAP) || (32'(in_va) >= VIRT_LIMIT);
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_pa = phys(map_rdata, r_offs);
                if (r_range) begin
                    res.status = ST_RANGE;
                    res.read_data = (r_cmd == CMD_READ) ? FAULT_BYTE : '0;
                    if (slot) begin
                        load_res = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    unique case (r_cmd)
                        CMD_UNMAP: begin
                            if (slot) begin
                                ctl.map_we = 1'b1;
                                // frame returns to the free set
                                ctl.used_we = (map_rdata != '0);
                                used_waddr = map_rdata;
                                load_res = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                        CMD_READ: begin
                            if (map_rdata == '0) begin
                                res.status = ST_UNMAPPED;
                                res.read_data = FAULT_BYTE;
                                if (slot) begin
                                    load_res = 1'b1;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                st_re = 1'b1;
                                n_state = S_ACCESS;
                            end
                        end
                        CMD_WRITE: begin
                            if (map_rdata != '0) begin
                                res.phys_addr = PA_W'(32'(phys(map_rdata, r_offs)));
                                if (slot) begin
                                    st_we = 1'b1;
                                    load_res = 1'b1;
                                    n_state = S_IDLE;
                                end
                            end else if (r_va == '0) begin
                                res.status = ST_GUARD;
                                if (slot) begin
                                    load_res = 1'b1;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_cand = next_frame(r_alloc);
                                n_chk_v = 1'b0;
                                n_cnt = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                res.read_data = st_rdata;
                res.phys_addr = PA_W'(32'(r_pa));
                if (slot) begin
                    load_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                // issue one frame per cycle, check the one issued last cycle
                ctl.used_re = 1'b1;
                n_chk = r_cand;
                n_chk_v = 1'b1;
                n_cand = next_frame(r_cand);
                if (r_chk_v) begin
                    if (r_chk != '0 && !used_rdata) begin
                        n_chk = r_chk;
                        n_found_ok = 1'b1;
                        n_state = S_ALLOC;
                    end else if (32'(r_cnt) == NUM_PAGES - 1) begin
                        n_found_ok = 1'b0;
                        n_state = S_ALLOC;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                st_addr = phys(r_chk, r_offs);
                if (r_found_ok) begin
                    res.phys_addr = PA_W'(32'(phys(r_chk, r_offs)));
                end else begin
                    res.status = ST_NOFRAME;
                end
                if (slot) begin
                    load_res = 1'b1;
                    n_state = S_IDLE;
                    if (r_found_ok) begin
                        ctl.map_we = 1'b1;
                        map_wdata = r_chk;
                        ctl.used_we = 1'b1;
                        ctl.used_wdata = 1'b1;
                        st_we = 1'b1;
                        n_alloc = r_chk;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_alloc     <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_alloc <= n_alloc;
            r_chk_v <= n_chk_v;
            if (load_res) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_va       <= n_va;
        r_wd       <= n_wd;
        r_range    <= n_range;
        r_cand     <= n_cand;
        r_chk      <= n_chk;
        r_cnt      <= n_cnt;
        r_found_ok <= n_found_ok;
        r_pa       <= n_pa;
        if (load_res) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(TDATA_W - RES_W)'(0), r_res};

    // frame 0 stands for unmapped and is never marked in use
    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.used_we && ctl.used_wdata) |-> (used_waddr != '0))
        else $error("frame zero marked in use");

    a_accept_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> (r_state == S_LOOKUP))
        else $error("accepted command did not start a table lookup");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (32'(r_cnt) < NUM_PAGES))
        else $error("frame search ran past one lap");

    a_access_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACCESS) |-> (r_cmd == CMD_READ && !r_range))
        else $error("byte memory read for a command that is not a mapped read");

endmodule
